>>> rtl/kta_pkg.sv
// ----------------------------------------------------------------------------
// kta_pkg
// Shared types, key codes and character tables for the key code translator.
// ----------------------------------------------------------------------------
package kta_pkg;

  localparam int unsigned CodeW = 10;
  localparam int unsigned ValW  = 2;
  localparam int unsigned ModW  = 4;
  localparam int unsigned CharW = 8;
  localparam int unsigned TableLen = 58;

  // modifier bit positions
  localparam int unsigned ModShift = 0;
  localparam int unsigned ModCtrl  = 1;
  localparam int unsigned ModAlt   = 2;
  localparam int unsigned ModCaps  = 3;

  // event values
  localparam logic [ValW-1:0] ValRelease = 2'd0;
  localparam logic [ValW-1:0] ValPress   = 2'd1;

  // key codes
  localparam logic [CodeW-1:0] KcEsc    = 10'd1;
  localparam logic [CodeW-1:0] Kc6      = 10'd7;
  localparam logic [CodeW-1:0] KcMinus  = 10'd12;
  localparam logic [CodeW-1:0] KcTab    = 10'd15;
  localparam logic [CodeW-1:0] KcLbrace = 10'd26;
  localparam logic [CodeW-1:0] KcRbrace = 10'd27;
  localparam logic [CodeW-1:0] KcLctrl  = 10'd29;
  localparam logic [CodeW-1:0] KcLshift = 10'd42;
  localparam logic [CodeW-1:0] KcBslash = 10'd43;
  localparam logic [CodeW-1:0] KcRshift = 10'd54;
  localparam logic [CodeW-1:0] KcLalt   = 10'd56;
  localparam logic [CodeW-1:0] KcSpace  = 10'd57;
  localparam logic [CodeW-1:0] KcCaps   = 10'd58;
  localparam logic [CodeW-1:0] KcRctrl  = 10'd97;
  localparam logic [CodeW-1:0] KcRalt   = 10'd100;
  localparam logic [CodeW-1:0] KcUp     = 10'd103;
  localparam logic [CodeW-1:0] KcLeft   = 10'd105;
  localparam logic [CodeW-1:0] KcRight  = 10'd106;
  localparam logic [CodeW-1:0] KcDown   = 10'd108;

  // control characters
  localparam logic [CharW-1:0] ChNone = 8'd0;
  localparam logic [CharW-1:0] ChEsc  = 8'd27;
  localparam logic [CharW-1:0] ChFs   = 8'd28;
  localparam logic [CharW-1:0] ChGs   = 8'd29;
  localparam logic [CharW-1:0] ChRs   = 8'd30;
  localparam logic [CharW-1:0] ChUs   = 8'd31;
  localparam logic [CharW-1:0] ChBs   = 8'd8;
  localparam logic [CharW-1:0] ChTab  = 8'd9;
  localparam logic [CharW-1:0] ChLf   = 8'd10;
  localparam logic [CharW-1:0] ChLowA = 8'h61;
  localparam logic [CharW-1:0] ChLowZ = 8'h7A;
  localparam logic [CharW-1:0] ChCtrlBase = 8'h60;

  // register indexes
  localparam logic [1:0] RegUp    = 2'd0;
  localparam logic [1:0] RegDown  = 2'd1;
  localparam logic [1:0] RegLeft  = 2'd2;
  localparam logic [1:0] RegRight = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] up;
    logic [CharW-1:0] down;
    logic [CharW-1:0] left;
    logic [CharW-1:0] right;
  } arrow_codes_t;

  typedef struct packed {
    logic [ModW-1:0]  mods;
    logic [CharW-1:0] ch;
    logic             sw;
  } xlate_res_t;

  function automatic logic [CharW-1:0] plain_char(input logic [5:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      6'd1:  c = ChEsc;
      6'd2:  c = "1";
      6'd3:  c = "2";
      6'd4:  c = "3";
      6'd5:  c = "4";
      6'd6:  c = "5";
      6'd7:  c = "6";
      6'd8:  c = "7";
      6'd9:  c = "8";
      6'd10: c = "9";
      6'd11: c = "0";
      6'd12: c = "-";
      6'd13: c = "=";
      6'd14: c = ChBs;
      6'd15: c = ChTab;
      6'd16: c = "q";
      6'd17: c = "w";
      6'd18: c = "e";
      6'd19: c = "r";
      6'd20: c = "t";
      6'd21: c = "y";
      6'd22: c = "u";
      6'd23: c = "i";
      6'd24: c = "o";
      6'd25: c = "p";
      6'd26: c = "[";
      6'd27: c = "]";
      6'd28: c = ChLf;
      6'd30: c = "a";
      6'd31: c = "s";
      6'd32: c = "d";
      6'd33: c = "f";
      6'd34: c = "g";
      6'd35: c = "h";
      6'd36: c = "j";
      6'd37: c = "k";
      6'd38: c = "l";
      6'd39: c = ";";
      6'd40: c = 8'h27;
      6'd41: c = 8'h60;
      6'd43: c = 8'h5C;
      6'd44: c = "z";
      6'd45: c = "x";
      6'd46: c = "c";
      6'd47: c = "v";
      6'd48: c = "b";
      6'd49: c = "n";
      6'd50: c = "m";
      6'd51: c = ",";
      6'd52: c = ".";
      6'd53: c = "/";
      6'd57: c = " ";
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] shift_char(input logic [5:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      6'd2:  c = "!";
      6'd3:  c = "@";
      6'd4:  c = "#";
      6'd5:  c = "$";
      6'd6:  c = "%";
      6'd7:  c = "^";
      6'd8:  c = "&";
      6'd9:  c = "*";
      6'd10: c = "(";
      6'd11: c = ")";
      6'd12: c = "_";
      6'd13: c = "+";
      6'd16: c = "Q";
      6'd17: c = "W";
      6'd18: c = "E";
      6'd19: c = "R";
      6'd20: c = "T";
      6'd21: c = "Y";
      6'd22: c = "U";
      6'd23: c = "I";
      6'd24: c = "O";
      6'd25: c = "P";
      6'd26: c = "{";
      6'd27: c = "}";
      6'd30: c = "A";
      6'd31: c = "S";
      6'd32: c = "D";
      6'd33: c = "F";
      6'd34: c = "G";
      6'd35: c = "H";
      6'd36: c = "J";
      6'd37: c = "K";
      6'd38: c = "L";
      6'd39: c = ":";
      6'd40: c = 8'h22;
      6'd41: c = "~";
      6'd43: c = "|";
      6'd44: c = "Z";
      6'd45: c = "X";
      6'd46: c = "C";
      6'd47: c = "V";
      6'd48: c = "B";
      6'd49: c = "N";
      6'd50: c = "M";
      6'd51: c = "<";
      6'd52: c = ">";
      6'd53: c = "?";
      default: c = plain_char(idx);
    endcase
    return c;
  endfunction

endpackage

>>> rtl/kta_xlate.sv
// ----------------------------------------------------------------------------
// kta_xlate
// Modifier update and key code to character translation for one event.
// ----------------------------------------------------------------------------
module kta_xlate import kta_pkg::*; (
  input  logic [CodeW-1:0] code,
  input  logic [ValW-1:0]  value,
  input  logic [ModW-1:0]  mods_cur,
  input  arrow_codes_t     arrows,
  output xlate_res_t       res
);

  logic [ModW-1:0]  mods_next;
  logic [CharW-1:0] base;
  logic [CharW-1:0] shifted;
  logic [CharW-1:0] ch;
  logic             shift, ctrl, caps, alt_tab;

  always_comb begin
    mods_next = mods_cur;
    if (code == KcLshift || code == KcRshift) begin
      mods_next[ModShift] = (value != ValRelease);
    end else if (code == KcLctrl || code == KcRctrl) begin
      mods_next[ModCtrl] = (value != ValRelease);
    end else if (code == KcLalt || code == KcRalt) begin
      mods_next[ModAlt] = (value != ValRelease);
    end else if (code == KcCaps && value == ValPress) begin
      mods_next[ModCaps] = ~mods_cur[ModCaps];
    end
  end

  assign shift   = mods_next[ModShift];
  assign ctrl    = mods_next[ModCtrl];
  assign caps    = mods_next[ModCaps];
  assign base    = plain_char(code[5:0]);
  assign shifted = shift_char(code[5:0]);
  assign alt_tab = (code == KcTab) && (value == ValPress) && mods_next[ModAlt];

  always_comb begin
    ch = ChNone;
    if (value == ValRelease || alt_tab) begin
      ch = ChNone;
    end else if (code == KcUp) begin
      ch = arrows.up;
    end else if (code == KcDown) begin
      ch = arrows.down;
    end else if (code == KcLeft) begin
      ch = arrows.left;
    end else if (code == KcRight) begin
      ch = arrows.right;
    end else if (code >= CodeW'(TableLen)) begin
      ch = ChNone;
    end else if (base inside {[ChLowA:ChLowZ]}) begin
      if (ctrl) ch = base - ChCtrlBase;
      else ch = (shift != caps) ? shifted : base;
    end else if (ctrl && code == KcSpace) begin
      ch = ChNone;
    end else if (ctrl && code == Kc6) begin
      ch = ChRs;
    end else if (ctrl && code == KcMinus) begin
      ch = ChUs;
    end else if (ctrl && code == KcLbrace) begin
      ch = ChEsc;
    end else if (ctrl && code == KcRbrace) begin
      ch = ChGs;
    end else if (ctrl && code == KcBslash) begin
      ch = ChFs;
    end else begin
      ch = shift ? shifted : base;
    end
  end

  assign res.mods = mods_next;
  assign res.ch   = ch;
  assign res.sw   = alt_tab;

endmodule

>>> rtl/keycode_to_ascii_translator_core.sv
// ----------------------------------------------------------------------------
// keycode_to_ascii_translator_core
// Key event to character translator with modifier tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one key event: key_code and
//   key_value (0 release, 1 press, 2 repeat). Output channel
//   (out_valid/out_ready) returns exactly one transaction per event: the
//   echoed code and value, the modifiers after the update, the character
//   and the window-switch flag.
//   The event is registered on input, translated, and registered again
//   on output. Throughput is one event per cycle while out_ready is high.
//   The modifier register updates as an event moves into the output
//   register, so events see modifiers in arrival order.
//   When the receiver stalls, the output register holds and the input
//   register fills; in_ready drops only once both are full.
//   Reset clears both stages and the modifiers, and loads the arrow
//   registers with 128, 129, 130 and 131. Arrow registers sit on the APB
//   port at byte offsets 0, 4, 8, 12; write them only while idle.
// ----------------------------------------------------------------------------
module keycode_to_ascii_translator_core import kta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CodeW-1:0] key_code,
  input  logic [ValW-1:0]  key_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CodeW-1:0] code_echo,
  output logic [ValW-1:0]  value_echo,
  output logic [ModW-1:0]  modifier_bits,
  output logic [CharW-1:0] char_out,
  output logic             window_switch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             s1_valid;
  logic [CodeW-1:0] s1_code;
  logic [ValW-1:0]  s1_value;
  logic [ModW-1:0]  mods;
  arrow_codes_t     arrows;
  xlate_res_t       res;
  logic             advance;
  logic             s1_move;
  logic [1:0]       reg_idx;
  logic [CharW-1:0] rd_byte;

  assign advance  = !out_valid || out_ready;
  assign s1_move  = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code  <= key_code;
      s1_value <= key_value;
    end
  end

  kta_xlate u_xlate (
    .code     (s1_code),
    .value    (s1_value),
    .mods_cur (mods),
    .arrows   (arrows),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mods      <= '0;
    end else begin
      if (advance) out_valid <= s1_valid;
      if (s1_move) mods <= res.mods;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      code_echo     <= s1_code;
      value_echo    <= s1_value;
      modifier_bits <= res.mods;
      char_out      <= res.ch;
      window_switch <= res.sw;
    end
  end

  // configuration
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrows.up    <= 8'd128;
      arrows.down  <= 8'd129;
      arrows.left  <= 8'd130;
      arrows.right <= 8'd131;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegUp:    arrows.up    <= pwdata[CharW-1:0];
        RegDown:  arrows.down  <= pwdata[CharW-1:0];
        RegLeft:  arrows.left  <= pwdata[CharW-1:0];
        RegRight: arrows.right <= pwdata[CharW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegUp:    rd_byte = arrows.up;
      RegDown:  rd_byte = arrows.down;
      RegLeft:  rd_byte = arrows.left;
      RegRight: rd_byte = arrows.right;
      default:  rd_byte = ChNone;
    endcase
  end

  assign prdata = {24'd0, rd_byte};

endmodule

>>> rtl/kta_chk.sv
// ----------------------------------------------------------------------------
// kta_chk
// Port-level checks for the key code translator, bound to the top level.
// ----------------------------------------------------------------------------
module kta_chk import kta_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CodeW-1:0] code_echo,
  input logic [ValW-1:0]  value_echo,
  input logic [ModW-1:0]  modifier_bits,
  input logic [CharW-1:0] char_out,
  input logic             window_switch
);

  // a stalled transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(code_echo))
    else $error("output changed while stalled");

  // window switch only on an alt+tab press, and it suppresses the character
  a_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_switch |-> code_echo == KcTab && value_echo == ValPress &&
      modifier_bits[ModAlt] && char_out == ChNone)
    else $error("bad window switch");

  // releases never produce a character
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_echo == ValRelease |-> char_out == ChNone && !window_switch)
    else $error("character on release");

  // shift key held shows in the modifiers of its own transaction
  a_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid && (code_echo == KcLshift || code_echo == KcRshift) |->
      modifier_bits[ModShift] == (value_echo != ValRelease))
    else $error("shift modifier not tracked");

endmodule

bind keycode_to_ascii_translator_core kta_chk u_kta_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .code_echo     (code_echo),
  .value_echo    (value_echo),
  .modifier_bits (modifier_bits),
  .char_out      (char_out),
  .window_switch (window_switch)
);
